/* design/dras_pkg.sv */
// Shared constants and types for the dual ring audio switch.
`default_nettype none

package dras_pkg;

    localparam int unsigned REQ_W      = 3;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned PAIR_W     = 2 * SAMPLE_W;
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned KEEP_W     = 13;
    localparam int unsigned GRACE_W    = 20;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned OUT_DATA_W = 56;

    localparam logic [CFG_ADDR_W-1:0] CFG_RING_SIZE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAIL_KEEP     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRACE_TICKS   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_ENABLE = 2'd3;

    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BEGIN  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COMMIT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RESET  = 3'd5;

    localparam logic [SIZE_W-1:0]  RST_RING_SIZE   = 13'd4096;
    localparam logic [KEEP_W-1:0]  RST_TAIL_KEEP   = 13'd256;
    localparam logic [GRACE_W-1:0] RST_GRACE_TICKS = 20'd500000;

    typedef struct packed {
        logic              popped;
        logic              drop;
        logic              read_ring;
        logic              draining;
        logic [SIZE_W-1:0] read_fill;
        logic              committed;
    } t_status;

endpackage

`default_nettype wire

/* design/dual_ring_audio_switch.sv */
// Top level of the dual ring audio switch: control state, ring memory and stream ports.
`default_nettype none

// Two stereo rings share one sample memory of 2*RING_DEPTH pairs with a registered read
// port. Every request beat produces one result beat. The block takes one beat per clock
// while m_axis_tready keeps the output moving; a result passes the ring memory read and
// status registers, then the output register. Positions, fills and transition state
// update in the accept cycle, so consecutive requests never wait on each other. The ring
// memory is not cleared at reset; a read after a size change can hit an unwritten entry.
module dual_ring_audio_switch #(
    parameter int unsigned RING_DEPTH = 4096
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [dras_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [dras_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // left_in [15:0], right_in [31:16]
    input  wire  [dras_pkg::PAIR_W-1:0]          s_axis_tdata,
    // req_type [2:0]
    input  wire  [dras_pkg::REQ_W-1:0]           s_axis_tuser,
    input  wire                                  s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // left_out [15:0], right_out [31:16], sample_valid [32], overflow_drop [33],
    // read_ring [34], draining [35], read_fill [48:36], committed [49], zero [55:50]
    output logic [dras_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import dras_pkg::*;

    localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned FW = $clog2(RING_DEPTH + 1);
    localparam int unsigned CW = (FW > SIZE_W) ? FW : SIZE_W;
    localparam int unsigned AW = $clog2(2 * RING_DEPTH);
    localparam int unsigned MEM_DEPTH = 2 * RING_DEPTH;

    // configuration
    logic [SIZE_W-1:0]  r_ring_size;
    logic [KEEP_W-1:0]  r_tail_keep;
    logic [GRACE_W-1:0] r_grace_ticks;
    logic               r_output_enable;

    // ring control state
    logic [PW-1:0]      r_wpos [2];
    logic [PW-1:0]      r_rpos [2];
    logic [FW-1:0]      r_fill [2];
    logic               r_rsel;
    logic               r_wsel;
    logic               r_drain;
    logic               r_new_seen;
    logic [GRACE_W-1:0] r_deadline;

    logic [PW-1:0]      n_wpos [2];
    logic [PW-1:0]      n_rpos [2];
    logic [FW-1:0]      n_fill [2];
    logic               n_rsel;
    logic               n_wsel;
    logic               n_drain;
    logic               n_new_seen;
    logic [GRACE_W-1:0] n_deadline;

    // ring memory
    logic [PAIR_W-1:0]  r_mem [MEM_DEPTH];
    logic [PAIR_W-1:0]  r_rdata;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;

    // pipeline
    logic               r_p_valid;
    t_status            r_p_stat;
    t_status            n_stat;
    logic               r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic               p_adv;
    logic               accept;

    logic [CW-1:0]      eff_size;
    logic [REQ_W-1:0]   req;

    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] pos,
                                            input logic [CW-1:0] size);
        logic [CW-1:0] nx;
        nx = CW'(pos) + CW'(1);
        return (nx >= size) ? '0 : nx[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic ring, input logic [PW-1:0] pos);
        return ring ? (AW'(RING_DEPTH) + AW'(pos)) : AW'(pos);
    endfunction

    assign req    = s_axis_tuser;
    assign p_adv  = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || p_adv;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (r_ring_size == '0) begin
            eff_size = CW'(1);
        end else if (CW'(r_ring_size) > CW'(RING_DEPTH)) begin
            eff_size = CW'(RING_DEPTH);
        end else begin
            eff_size = CW'(r_ring_size);
        end
    end

    always_comb begin
        logic          w;
        logic          r;
        logic          do_check;
        logic [CW-1:0] fill_x;

        n_wpos     = r_wpos;
        n_rpos     = r_rpos;
        n_fill     = r_fill;
        n_rsel     = r_rsel;
        n_wsel     = r_wsel;
        n_drain    = r_drain;
        n_new_seen = r_new_seen;
        n_deadline = r_deadline;
        n_stat     = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = f_addr(r_wsel, r_wpos[r_wsel]);
        mem_raddr  = f_addr(r_rsel, r_rpos[r_rsel]);
        do_check   = 1'b0;
        fill_x     = '0;
        w          = r_wsel;
        r          = r_rsel;

        if (accept) begin
            case (req)
                REQ_WRITE: begin
                    if (r_drain) begin
                        n_new_seen = 1'b1;
                    end
                    fill_x = CW'(r_fill[w]);
                    if (fill_x >= eff_size) begin
                        n_rpos[w]   = f_adv(r_rpos[w], eff_size);
                        fill_x      = eff_size - CW'(1);
                        n_stat.drop = 1'b1;
                    end
                    mem_we    = 1'b1;
                    n_wpos[w] = f_adv(r_wpos[w], eff_size);
                    n_fill[w] = FW'(fill_x + CW'(1));
                    do_check  = s_axis_tlast;
                end
                REQ_READ: begin
                    if (r_output_enable) begin
                        if (r_fill[r] != '0) begin
                            mem_re        = 1'b1;
                            n_stat.popped = 1'b1;
                            n_rpos[r]     = f_adv(r_rpos[r], eff_size);
                            n_fill[r]     = r_fill[r] - FW'(1);
                        end
                        do_check = s_axis_tlast;
                    end
                end
                REQ_BEGIN: begin
                    if (!r_drain) begin
                        n_wpos[~r_rsel] = '0;
                        n_rpos[~r_rsel] = '0;
                        n_fill[~r_rsel] = '0;
                        n_wsel          = ~r_rsel;
                        n_drain         = 1'b1;
                        n_new_seen      = 1'b0;
                        n_deadline      = r_grace_ticks;
                    end
                end
                REQ_COMMIT: begin
                    do_check = 1'b1;
                end
                REQ_TICK: begin
                    if (r_deadline != '0) begin
                        n_deadline = r_deadline - GRACE_W'(1);
                    end
                end
                REQ_RESET: begin
                    n_wpos     = '{default: '0};
                    n_rpos     = '{default: '0};
                    n_fill     = '{default: '0};
                    n_rsel     = 1'b0;
                    n_wsel     = 1'b0;
                    n_drain    = 1'b0;
                    n_new_seen = 1'b0;
                end
                default: begin
                end
            endcase

            if (do_check && r_drain) begin
                if ((n_new_seen && (CW'(n_fill[r_rsel]) <= CW'(r_tail_keep)))
                        || (n_deadline == '0)) begin
                    n_rsel           = r_wsel;
                    n_drain          = 1'b0;
                    n_new_seen       = 1'b0;
                    n_stat.committed = 1'b1;
                end
            end

            n_stat.read_ring = n_rsel;
            n_stat.draining  = n_drain;
            n_stat.read_fill = SIZE_W'(CW'(n_fill[n_rsel]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= s_axis_tdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size     <= RST_RING_SIZE;
            r_tail_keep     <= RST_TAIL_KEEP;
            r_grace_ticks   <= RST_GRACE_TICKS;
            r_output_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_RING_SIZE:     r_ring_size     <= i_cfg_data[SIZE_W-1:0];
                CFG_TAIL_KEEP:     r_tail_keep     <= i_cfg_data[KEEP_W-1:0];
                CFG_GRACE_TICKS:   r_grace_ticks   <= i_cfg_data[GRACE_W-1:0];
                CFG_OUTPUT_ENABLE: r_output_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos     <= '{default: '0};
            r_rpos     <= '{default: '0};
            r_fill     <= '{default: '0};
            r_rsel     <= 1'b0;
            r_wsel     <= 1'b0;
            r_drain    <= 1'b0;
            r_new_seen <= 1'b0;
            r_deadline <= '0;
        end else begin
            r_wpos     <= n_wpos;
            r_rpos     <= n_rpos;
            r_fill     <= n_fill;
            r_rsel     <= n_rsel;
            r_wsel     <= n_wsel;
            r_drain    <= n_drain;
            r_new_seen <= n_new_seen;
            r_deadline <= n_deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (p_adv) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_stat <= n_stat;
        end
        if (p_adv) begin
            r_o_data <= {6'd0,
                         r_p_stat.committed,
                         r_p_stat.read_fill,
                         r_p_stat.draining,
                         r_p_stat.read_ring,
                         r_p_stat.drop,
                         r_p_stat.popped,
                         r_p_stat.popped ? r_rdata : {PAIR_W{1'b0}}};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule

`default_nettype wire

/* dv/dual_ring_audio_switch_checker.sv */
// Scoreboard for the dual ring audio switch: tracks ring state and checks every result beat.
`timescale 1ns / 100ps

module dual_ring_audio_switch_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [dras_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire  [dras_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_s_axis_tvalid,
    input  wire                                 i_s_axis_tready,
    // left_in [15:0], right_in [31:16]
    input  wire  [dras_pkg::PAIR_W-1:0]         i_s_axis_tdata,
    // req_type [2:0]
    input  wire  [dras_pkg::REQ_W-1:0]          i_s_axis_tuser,
    input  wire                                 i_s_axis_tlast,
    input  wire                                 i_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // left_out [15:0], right_out [31:16], sample_valid [32], overflow_drop [33],
    // read_ring [34], draining [35], read_fill [48:36], committed [49], zero [55:50]
    input  wire  [dras_pkg::OUT_DATA_W-1:0]     i_m_axis_tdata,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked
);
    import dras_pkg::*;

    localparam int unsigned DEPTH = 4096;
    localparam int unsigned POS_W = 12;

    typedef struct packed {
        logic [5:0]          pad;
        logic                committed;
        logic [SIZE_W-1:0]   fill;
        logic                draining;
        logic                ring;
        logic                drop;
        logic                popped;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } t_beat_result;

    logic [SIZE_W-1:0]  ring_len;
    logic [KEEP_W-1:0]  keep_lim;
    logic [GRACE_W-1:0] grace_load;
    logic               play_en;

    logic [PAIR_W-1:0]  pair_mem [0:2*DEPTH-1];
    logic [POS_W-1:0]   wr_ptr [2];
    logic [POS_W-1:0]   rd_ptr [2];
    logic [SIZE_W-1:0]  fill [2];
    logic               rd_sel;
    logic               wr_sel;
    logic               drain;
    logic               fresh;
    logic [GRACE_W-1:0] deadline;

    t_beat_result       due_results [$];

    function automatic logic [SIZE_W-1:0] span();
        if (ring_len == '0) begin
            return SIZE_W'(1);
        end
        if (ring_len > SIZE_W'(DEPTH)) begin
            return SIZE_W'(DEPTH);
        end
        return ring_len;
    endfunction

    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p);
        logic [SIZE_W-1:0] n;
        n = {1'b0, p} + 1'b1;
        return (n >= span()) ? '0 : n[POS_W-1:0];
    endfunction

    task automatic clear_ring(input logic idx);
        wr_ptr[idx] = '0;
        rd_ptr[idx] = '0;
        fill[idx]   = '0;
    endtask

    function automatic logic try_switch();
        if (!drain) begin
            return 1'b0;
        end
        if ((fresh && fill[rd_sel] <= keep_lim) || deadline == '0) begin
            rd_sel = wr_sel;
            drain  = 1'b0;
            fresh  = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_request(input logic [REQ_W-1:0] req, input logic [PAIR_W-1:0] pair,
                                   input logic last, output t_beat_result r);
        logic              w;
        logic [SIZE_W-1:0] sz;
        logic [PAIR_W-1:0] word;
        r = '0;
        case (req)
            REQ_WRITE: begin
                w  = wr_sel;
                sz = span();
                if (drain) begin
                    fresh = 1'b1;
                end
                if (fill[w] >= sz) begin
                    rd_ptr[w] = step_pos(rd_ptr[w]);
                    fill[w]   = sz - 1'b1;
                    r.drop    = 1'b1;
                end
                pair_mem[{w, wr_ptr[w]}] = pair;
                wr_ptr[w] = step_pos(wr_ptr[w]);
                fill[w]   = fill[w] + 1'b1;
                if (last) begin
                    r.committed = try_switch();
                end
            end
            REQ_READ: begin
                if (play_en) begin
                    if (fill[rd_sel] != '0) begin
                        word         = pair_mem[{rd_sel, rd_ptr[rd_sel]}];
                        r.left       = word[SAMPLE_W-1:0];
                        r.right      = word[PAIR_W-1:SAMPLE_W];
                        r.popped     = 1'b1;
                        rd_ptr[rd_sel] = step_pos(rd_ptr[rd_sel]);
                        fill[rd_sel] = fill[rd_sel] - 1'b1;
                    end
                    if (last) begin
                        r.committed = try_switch();
                    end
                end
            end
            REQ_BEGIN: begin
                if (!drain) begin
                    w = ~rd_sel;
                    clear_ring(w);
                    wr_sel   = w;
                    drain    = 1'b1;
                    fresh    = 1'b0;
                    deadline = grace_load;
                end
            end
            REQ_COMMIT: begin
                r.committed = try_switch();
            end
            REQ_TICK: begin
                if (deadline != '0) begin
                    deadline = deadline - 1'b1;
                end
            end
            REQ_RESET: begin
                clear_ring(1'b0);
                clear_ring(1'b1);
                rd_sel = 1'b0;
                wr_sel = 1'b0;
                drain  = 1'b0;
                fresh  = 1'b0;
            end
            default: begin
            end
        endcase
        r.ring     = rd_sel;
        r.draining = drain;
        r.fill     = fill[rd_sel];
    endtask

    always @(posedge i_clk) begin : watch
        t_beat_result want;
        t_beat_result got;
        if (!i_rst_n) begin
            ring_len   = RST_RING_SIZE;
            keep_lim   = RST_TAIL_KEEP;
            grace_load = RST_GRACE_TICKS;
            play_en    = 1'b1;
            clear_ring(1'b0);
            clear_ring(1'b1);
            rd_sel     = 1'b0;
            wr_sel     = 1'b0;
            drain      = 1'b0;
            fresh      = 1'b0;
            deadline   = '0;
            due_results.delete();
            o_errors   = 0;
            o_checked  = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (due_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: result beat with nothing outstanding: expected none, actual %h",
                             $time, i_m_axis_tdata);
                end else begin
                    want = due_results.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_errors++;
                        $display({"%0t: result mismatch: expected L=%h R=%h pop=%b drop=%b ",
                                  "ring=%b drain=%b fill=%0d commit=%b pad=%h"},
                                 $time, want.left, want.right, want.popped, want.drop,
                                 want.ring, want.draining, want.fill, want.committed, want.pad);
                        $display({"%0t:                  actual L=%h R=%h pop=%b drop=%b ",
                                  "ring=%b drain=%b fill=%0d commit=%b pad=%h"},
                                 $time, got.left, got.right, got.popped, got.drop,
                                 got.ring, got.draining, got.fill, got.committed, got.pad);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_RING_SIZE:     ring_len   = i_cfg_data[SIZE_W-1:0];
                    CFG_TAIL_KEEP:     keep_lim   = i_cfg_data[KEEP_W-1:0];
                    CFG_GRACE_TICKS:   grace_load = i_cfg_data[GRACE_W-1:0];
                    CFG_OUTPUT_ENABLE: play_en    = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_request(i_s_axis_tuser, i_s_axis_tdata, i_s_axis_tlast, want);
                due_results.push_back(want);
            end
        end
        o_pending = due_results.size();
    end

endmodule

/* dv/dual_ring_audio_switch_test.sv */
// Testbench top for the dual ring audio switch: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module dual_ring_audio_switch_test;
    import dras_pkg::*;

    localparam int PRELOAD_PAIRS  = 128;
    localparam int PHASES         = 7;
    localparam int RANDOM_BEATS   = 52;
    localparam int IDLE_PCT       = 24;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 60000;

    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PAIR_W-1:0]     s_axis_tdata  = '0;
    logic [REQ_W-1:0]      s_axis_tuser  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic calm   = 1'b0;
    int   cycles = 0;
    int   sent   = 0;
    int   chk_errors;
    int   chk_pending;
    int   chk_checked;

    dual_ring_audio_switch dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dual_ring_audio_switch_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_errors        (chk_errors),
        .o_pending       (chk_pending),
        .o_checked       (chk_checked)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_beat(input logic [REQ_W-1:0] req, input logic [PAIR_W-1:0] pair,
                             input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= pair;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [SIZE_W-1:0] len, input logic [KEEP_W-1:0] keep,
                                  input logic [GRACE_W-1:0] grace, input logic en);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_RING_SIZE;
        i_cfg_data <= CFG_DATA_W'(len);
        @(negedge i_clk);
        i_cfg_addr <= CFG_TAIL_KEEP;
        i_cfg_data <= CFG_DATA_W'(keep);
        @(negedge i_clk);
        i_cfg_addr <= CFG_GRACE_TICKS;
        i_cfg_data <= grace;
        @(negedge i_clk);
        i_cfg_addr <= CFG_OUTPUT_ENABLE;
        i_cfg_data <= CFG_DATA_W'(en);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_sequence(inout int count);
        int               pick;
        int               len;
        logic [REQ_W-1:0] noise_req;
        pick = $urandom_range(0, 99);
        if (pick < 33) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) send_beat(REQ_WRITE, $urandom(), k == len - 1);
            count += len;
        end else if (pick < 63) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) send_beat(REQ_READ, $urandom(), k == len - 1);
            count += len;
        end else if (pick < 71) begin
            send_beat(REQ_BEGIN, $urandom(), 1'($urandom_range(0, 1)));
            count++;
        end else if (pick < 78) begin
            send_beat(REQ_COMMIT, $urandom(), 1'($urandom_range(0, 1)));
            count++;
        end else if (pick < 88) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
                send_beat(REQ_TICK, $urandom(), 1'($urandom_range(0, 1)));
            end
            count += len;
        end else if (pick < 90) begin
            send_beat(REQ_RESET, $urandom(), 1'($urandom_range(0, 1)));
            count++;
        end else if (pick < 92) begin
            wait_drained();
        end else begin
            noise_req = REQ_W'($urandom_range(0, 7));
            send_beat(noise_req, $urandom(), 1'($urandom_range(0, 1)));
            if (noise_req <= REQ_RESET) begin
                count++;
            end
        end
    endtask

    initial begin : stimulus
        int beats;
        int total_errors;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // preload the low entries of both rings so no read can hit an unwritten entry
        for (int k = 0; k < PRELOAD_PAIRS; k++) send_beat(REQ_WRITE, $urandom(), 1'b0);
        send_beat(REQ_BEGIN, '0, 1'b0);
        for (int k = 0; k < PRELOAD_PAIRS; k++) begin
            send_beat(REQ_WRITE, $urandom(), k == PRELOAD_PAIRS - 1);
        end
        send_beat(REQ_RESET, '0, 1'b0);

        send_beat(REQ_WRITE, {16'h7FFF, 16'h8000}, 1'b0);
        send_beat(REQ_WRITE, {16'h8000, 16'h7FFF}, 1'b0);
        send_beat(REQ_WRITE, {16'h0000, 16'h0000}, 1'b0);
        send_beat(REQ_WRITE, {16'hFFFF, 16'hFFFF}, 1'b1);
        for (int k = 0; k < 5; k++) send_beat(REQ_READ, '0, k == 4);
        send_beat(REQ_TICK, '0, 1'b0);
        send_beat(REQ_BEGIN, '0, 1'b0);
        send_beat(REQ_BEGIN, '1, 1'b1);
        send_beat(REQ_COMMIT, '0, 1'b0);
        send_beat(REQ_WRITE, {16'h5678, 16'h1234}, 1'b1);
        send_beat(REQ_COMMIT, '0, 1'b1);
        send_beat(REQ_SPARE_A, $urandom(), 1'b1);
        send_beat(REQ_SPARE_B, $urandom(), 1'b0);
        send_beat(REQ_READ, '0, 1'b1);
        send_beat(REQ_RESET, '0, 1'b1);
        send_beat(REQ_READ, '0, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            case (ph)
                0: write_settings(13'd4,    13'd0,    20'd0,       1'b1);
                1: write_settings(13'd0,    13'd8191, 20'd3,       1'b1);
                2: write_settings(13'd8191, 13'd4096, 20'd1048575, 1'b0);
                3: write_settings(13'd2,    13'd1,    20'd5,       1'b1);
                4: write_settings(13'd7,    13'd3,    20'd12,      1'b1);
                5: write_settings(13'd16,   13'd2,    20'd20,      1'b1);
                default: write_settings(13'd4096, 13'd0, 20'd2,    1'b1);
            endcase
            calm <= (ph == 3);
            @(negedge i_clk);
            beats = 0;
            while (beats < RANDOM_BEATS) run_sequence(beats);
        end

        wait_drained();
        calm <= 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        total_errors = chk_errors + chk_pending;
        if (chk_pending != 0) begin
            $display("%0t: %0d results never arrived", $time, chk_pending);
        end
        $display("Covered %0d request beats over %0d register settings, incl. ring preload.",
                 sent, PHASES + 1);
        $display("Checked %0d result beats across writes, reads, transitions and ticks.",
                 chk_checked);
        if (total_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* dual_ring_audio_switch.f */
design/dras_pkg.sv
design/dual_ring_audio_switch.sv
dv/dual_ring_audio_switch_checker.sv
dv/dual_ring_audio_switch_test.sv
